// ===== design/uf2ibc_pkg.sv =====
// Package for the UF2 image block checker.
// Holds field widths, magic numbers, header flag bit positions, result and status codes.
// No dependencies.
package uf2ibc_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 2;
  localparam int COUNT_W   = 3;
  localparam int STATUS_W  = 4;
  localparam int BLOCKS_W  = 16;
  localparam int END_W     = 33;
  localparam int WIDX_W    = 7;
  localparam int FLAGS_W   = 3;

  localparam int BLOCK_WORDS       = 128;
  localparam int MAX_PAYLOAD_BYTES = 476;

  localparam logic [WORD_W-1:0] MAGIC_A   = 32'h0A32_4655;
  localparam logic [WORD_W-1:0] MAGIC_B   = 32'h9E5D_5157;
  localparam logic [WORD_W-1:0] MAGIC_END = 32'h0AB1_6F30;

  localparam int FL_NOT_MAIN_BIT  = 0;
  localparam int FL_CONTAINER_BIT = 12;
  localparam int FL_FAMILY_BIT    = 13;

  localparam logic [WIDX_W-1:0] W_MAGIC_A   = 7'd0;
  localparam logic [WIDX_W-1:0] W_MAGIC_B   = 7'd1;
  localparam logic [WIDX_W-1:0] W_FLAGS     = 7'd2;
  localparam logic [WIDX_W-1:0] W_ADDRESS   = 7'd3;
  localparam logic [WIDX_W-1:0] W_SIZE      = 7'd4;
  localparam logic [WIDX_W-1:0] W_NUMBLOCKS = 7'd6;
  localparam logic [WIDX_W-1:0] W_FAMILY    = 7'd7;
  localparam logic [WIDX_W-1:0] W_DATA      = 7'd8;
  localparam logic [WIDX_W-1:0] W_MAGIC_END = 7'(BLOCK_WORDS - 1);

  localparam logic REG_IMAGE_BLOCKS    = 1'b0;
  localparam logic REG_EXPECTED_FAMILY = 1'b1;

  localparam logic [BLOCKS_W-1:0] IMAGE_BLOCKS_RESET    = 16'd1;
  localparam logic [WORD_W-1:0]   EXPECTED_FAMILY_RESET = 32'hE48B_FF56;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_START_MAGIC = 4'd1;
  localparam logic [STATUS_W-1:0] ST_END_MAGIC   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCK_COUNT = 4'd3;
  localparam logic [STATUS_W-1:0] ST_CONTAINER   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FAMILY      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_SIZE        = 4'd6;
  localparam logic [STATUS_W-1:0] ST_WRAP        = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NO_PAYLOAD  = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   write_address;
    logic [WORD_W-1:0]   write_data;
    logic [COUNT_W-1:0]  byte_count;
    logic [STATUS_W-1:0] status;
    logic [BLOCKS_W-1:0] loaded_count;
    logic [BLOCKS_W-1:0] skipped_count;
    logic [WORD_W-1:0]   lowest_address;
    logic [END_W-1:0]    highest_end;
    logic [WORD_W-1:0]   family_seen;
    logic                last;
  } result_t;

endpackage

// ===== design/uf2_image_block_checker.sv =====
// Top level of the UF2 image block checker: header checks, payload writes, totals.
// Depends on uf2ibc_pkg.
//
// Usage: image words enter on in_valid/in_ready/image_word, 128 words per
// 512-byte block. Each accepted word is held in an input register; there it
// is checked against the block state and its results (none, one or two) are
// written into a two-slot result buffer that drives the output channel, once
// the buffer has room for them. The results of a word reach the outputs from
// that buffer, behind any results still waiting in it.
// The block takes one word per cycle as long as the buffer has room for the
// word's results; the rate is set by that two-slot buffer alone.
// A payload word within the size of a good main-flash block gives a tentative
// write, the end-magic word a commit and, after the last block, a finish word
// with totals; a bad block gives one with the error code instead of a commit.
// After a finish word all further image words are taken and dropped.
// When the receiver stalls, results wait in the buffer and in_ready falls
// once the buffer cannot hold the results of the waiting word. Reset puts
// the control state in its start values, the image length at one block and
// the expected family at its default; cfg_write updates a register at once.
module uf2_image_block_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [uf2ibc_pkg::WORD_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [uf2ibc_pkg::WORD_W-1:0]       image_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [uf2ibc_pkg::KIND_W-1:0]       kind,
  output logic [uf2ibc_pkg::WORD_W-1:0]       write_address,
  output logic [uf2ibc_pkg::WORD_W-1:0]       write_data,
  output logic [uf2ibc_pkg::COUNT_W-1:0]      byte_count,
  output logic [uf2ibc_pkg::STATUS_W-1:0]     status,
  output logic [uf2ibc_pkg::BLOCKS_W-1:0]     loaded_count,
  output logic [uf2ibc_pkg::BLOCKS_W-1:0]     skipped_count,
  output logic [uf2ibc_pkg::WORD_W-1:0]       lowest_address,
  output logic [uf2ibc_pkg::END_W-1:0]        highest_end,
  output logic [uf2ibc_pkg::WORD_W-1:0]       family_seen,
  output logic                                last
);
  import uf2ibc_pkg::*;

  logic [BLOCKS_W-1:0] image_blocks;
  logic [WORD_W-1:0]   expected_family;

  logic                s_valid;
  logic [WORD_W-1:0]   s_word;
  logic                s_advance;

  logic [WIDX_W-1:0]   word_index, word_index_next;
  logic [BLOCKS_W-1:0] block_index, block_index_next;
  logic [FLAGS_W-1:0]  header_flags, header_flags_next;
  logic [WORD_W-1:0]   target_address, target_address_next;
  logic [WORD_W-1:0]   payload_length, payload_length_next;
  logic [STATUS_W-1:0] pending_error, pending_error_next;
  logic                start_magic_ok, start_magic_ok_next;
  logic [BLOCKS_W-1:0] loaded_total, loaded_total_next;
  logic [BLOCKS_W-1:0] skipped_total, skipped_total_next;
  logic [WORD_W-1:0]   low_mark, low_mark_next;
  logic [END_W-1:0]    high_mark, high_mark_next;
  logic [WORD_W-1:0]   family_value, family_value_next;
  logic                failed, failed_next;
  logic                image_done, image_done_next;

  result_t             res0, res1;
  logic [1:0]          res_n;

  result_t             slot0, slot1, slot0_next, slot1_next;
  logic [1:0]          count, count_next, rem, free;
  logic                pop;

  always_comb begin
    logic [WIDX_W-1:0]   wi;
    logic [WORD_W-1:0]   w;
    logic [STATUS_W-1:0] err;
    logic [END_W-1:0]    end_sum;
    logic [8:0]          off;
    logic [WORD_W-1:0]   off_w;
    logic [WORD_W-1:0]   left;
    logic [STATUS_W-1:0] st;
    logic [BLOCKS_W-1:0] block_inc;

    wi        = word_index;
    w         = s_word;
    err       = pending_error;
    end_sum   = {1'b0, target_address} + {1'b0, payload_length};
    off       = {wi - W_DATA, 2'b00};
    off_w     = {23'd0, off};
    left      = payload_length - off_w;
    st        = ST_OK;
    block_inc = block_index + 16'd1;

    word_index_next     = word_index;
    block_index_next    = block_index;
    header_flags_next   = header_flags;
    target_address_next = target_address;
    payload_length_next = payload_length;
    pending_error_next  = pending_error;
    start_magic_ok_next = start_magic_ok;
    loaded_total_next   = loaded_total;
    skipped_total_next  = skipped_total;
    low_mark_next       = low_mark;
    high_mark_next      = high_mark;
    family_value_next   = family_value;
    failed_next         = failed;
    image_done_next     = image_done;

    res0  = '0;
    res1  = '0;
    res_n = 2'd0;

    if (!(failed || image_done)) begin
      word_index_next = word_index + 7'd1;
      priority if (wi == W_MAGIC_A) begin
        start_magic_ok_next = (w == MAGIC_A);
        pending_error_next  = ST_OK;
        header_flags_next   = '0;
      end else if (wi == W_MAGIC_B) begin
        if (w != MAGIC_B) begin
          start_magic_ok_next = 1'b0;
        end
      end else if (wi == W_FLAGS) begin
        header_flags_next = {w[FL_FAMILY_BIT], w[FL_CONTAINER_BIT], w[FL_NOT_MAIN_BIT]};
      end else if (wi == W_ADDRESS) begin
        target_address_next = w;
      end else if (wi == W_SIZE) begin
        payload_length_next = w;
      end else if (wi == W_NUMBLOCKS) begin
        if (image_blocks == '0 || w != {16'd0, image_blocks}) begin
          pending_error_next = ST_BLOCK_COUNT;
        end
      end else if (wi == W_FAMILY) begin
        if (err == ST_OK && header_flags[1]) begin
          err = ST_CONTAINER;
        end
        if (err == ST_OK && header_flags[2]) begin
          if (start_magic_ok) begin
            family_value_next = w;
          end
          if (w != expected_family) begin
            err = ST_FAMILY;
          end
        end
        if (err == ST_OK && !header_flags[0] && payload_length != '0) begin
          if (payload_length > 32'(MAX_PAYLOAD_BYTES)) begin
            err = ST_SIZE;
          end else if (end_sum[32] && end_sum[31:0] != '0) begin
            err = ST_WRAP;
          end
        end
        pending_error_next = err;
      end else if (wi >= W_DATA && wi < W_MAGIC_END) begin
        if (start_magic_ok && pending_error == ST_OK && !header_flags[0] &&
            off_w < payload_length) begin
          res0.kind          = KIND_WRITE;
          res0.write_address = target_address + off_w;
          res0.write_data    = w;
          res0.byte_count    = (left > 32'd4) ? 3'd4 : left[2:0];
          res0.last          = 1'b1;
          res_n              = 2'd1;
        end
      end else if (wi == W_MAGIC_END) begin
        if (!start_magic_ok) begin
          st = ST_START_MAGIC;
        end else if (w != MAGIC_END) begin
          st = ST_END_MAGIC;
        end else begin
          st = pending_error;
        end
        if (st != ST_OK) begin
          failed_next = 1'b1;
          res0.kind   = KIND_DONE;
          res0.status = st;
          res0.last   = 1'b1;
          res_n       = 2'd1;
        end else begin
          if (header_flags[0]) begin
            skipped_total_next = skipped_total + 16'd1;
          end else if (payload_length != '0) begin
            loaded_total_next = loaded_total + 16'd1;
            if (target_address < low_mark) begin
              low_mark_next = target_address;
            end
            if (end_sum > high_mark) begin
              high_mark_next = end_sum;
            end
          end
          block_index_next = block_inc;
          res0.kind        = KIND_COMMIT;
          if (block_inc == image_blocks) begin
            image_done_next = 1'b1;
            res1.kind       = KIND_DONE;
            res1.status     = (loaded_total_next == '0) ? ST_NO_PAYLOAD : ST_OK;
            res1.last       = 1'b1;
            res_n           = 2'd2;
          end else begin
            res0.last = 1'b1;
            res_n     = 2'd1;
          end
        end
      end else begin
        word_index_next = word_index + 7'd1;
      end
    end

    res0.loaded_count   = loaded_total_next;
    res0.skipped_count  = skipped_total_next;
    res0.lowest_address = low_mark_next;
    res0.highest_end    = high_mark_next;
    res0.family_seen    = family_value_next;
    res1.loaded_count   = loaded_total_next;
    res1.skipped_count  = skipped_total_next;
    res1.lowest_address = low_mark_next;
    res1.highest_end    = high_mark_next;
    res1.family_seen    = family_value_next;
  end

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign rem       = count - {1'b0, pop};
  assign free      = 2'd2 - rem;
  assign s_advance = s_valid && (res_n <= free);
  assign in_ready  = !s_valid || s_advance;

  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    count_next = rem;
    if (s_advance && res_n != 2'd0) begin
      if (rem == 2'd0) begin
        slot0_next = res0;
        slot1_next = res1;
      end else begin
        slot1_next = res0;
      end
      count_next = rem + res_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_blocks    <= IMAGE_BLOCKS_RESET;
      expected_family <= EXPECTED_FAMILY_RESET;
      s_valid         <= 1'b0;
      count           <= 2'd0;
      word_index      <= '0;
      block_index     <= '0;
      header_flags    <= '0;
      target_address  <= '0;
      payload_length  <= '0;
      pending_error   <= ST_OK;
      start_magic_ok  <= 1'b1;
      loaded_total    <= '0;
      skipped_total   <= '0;
      low_mark        <= '1;
      high_mark       <= '0;
      family_value    <= '0;
      failed          <= 1'b0;
      image_done      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IMAGE_BLOCKS:    image_blocks    <= cfg_data[BLOCKS_W-1:0];
          REG_EXPECTED_FAMILY: expected_family <= cfg_data;
          default:             image_blocks    <= image_blocks;
        endcase
      end
      if (in_ready) begin
        s_valid <= in_valid;
      end
      count <= count_next;
      if (s_advance) begin
        word_index     <= word_index_next;
        block_index    <= block_index_next;
        header_flags   <= header_flags_next;
        target_address <= target_address_next;
        payload_length <= payload_length_next;
        pending_error  <= pending_error_next;
        start_magic_ok <= start_magic_ok_next;
        loaded_total   <= loaded_total_next;
        skipped_total  <= skipped_total_next;
        low_mark       <= low_mark_next;
        high_mark      <= high_mark_next;
        family_value   <= family_value_next;
        failed         <= failed_next;
        image_done     <= image_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s_word <= image_word;
    end
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  assign kind           = slot0.kind;
  assign write_address  = slot0.write_address;
  assign write_data     = slot0.write_data;
  assign byte_count     = slot0.byte_count;
  assign status         = slot0.status;
  assign loaded_count   = slot0.loaded_count;
  assign skipped_count  = slot0.skipped_count;
  assign lowest_address = slot0.lowest_address;
  assign highest_end    = slot0.highest_end;
  assign family_seen    = slot0.family_seen;
  assign last           = slot0.last;

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer holds more than two words");

  a_status_only_at_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DONE |-> status == ST_OK)
    else $error("status set on a write or commit word");

  a_write_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_WRITE |-> byte_count != 3'd0 && byte_count <= 3'd4)
    else $error("payload write with bad byte count");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    s_advance && !failed && !image_done |=> word_index == $past(word_index) + 7'd1)
    else $error("word index did not step with an accepted word");

endmodule
